### rtl/core/fwt_pkg.sv
package fwt_pkg;

	localparam int TABLE_ENTRIES_DEF = 16;
	localparam int THREAD_COUNT_DEF  = 32;
	localparam int ADDRESS_BITS_DEF  = 48;

	localparam int OP_W    = 2;
	localparam int ADDR_W  = 48;
	localparam int TNUM_W  = 5;
	localparam int CNT_W   = 6;
	localparam int KIND_W  = 2;

	localparam logic [OP_W-1:0] OP_REGISTER   = 2'd0;
	localparam logic [OP_W-1:0] OP_UNREGISTER = 2'd1;
	localparam logic [OP_W-1:0] OP_WAKE       = 2'd2;

	localparam logic [KIND_W-1:0] KIND_REGISTERED   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FULL         = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UNREGISTERED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_WAKE         = 2'd3;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] wait_address;
		logic [TNUM_W-1:0] thread_number;
		logic [CNT_W-1:0]  wake_limit;
	} fwt_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] reply_kind;
		logic [TNUM_W-1:0] woken_thread;
		logic              woken_valid;
		logic [CNT_W-1:0]  woken_so_far;
		logic              last_result;
	} fwt_result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_EMIT
	} fwt_state_t;

endpackage

### rtl/core/futex_waiter_table.sv
// futex waiter table
// a word is taken at a rising edge with start high and busy low; the item port
// carries operation, wait_address, thread_number and wake_limit. results come
// out on result, each valid for exactly one cycle while result_valid is high;
// the receiver cannot stall, so every result must be taken when shown
// the table sits in one ram (address and thread mask per entry) with one read
// and one write port; a sequencer walks it entry by entry (read, then compare
// and write back), starting at index zero:
//   register   : up to the first matching or free entry
//                (every entry when the table is full)
//   unregister : every entry
//   wake       : every entry, then the woken threads are picked lowest first,
//                one result per cycle, one per thread woken (a single empty
//                report when nothing is woken)
// a register or unregister for a thread out of range replies in the next cycle
// busy is high from acceptance until the final result has been issued; a new
// word can be taken in the cycle that the final result is shown
// reset clears all entry valid bits, so the table starts empty; the ram
// contents need no clearing since an entry is used only while valid
module futex_waiter_table import fwt_pkg::*; #(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int THREAD_COUNT  = THREAD_COUNT_DEF,
	parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  fwt_item_t   item,
	output fwt_result_t result,
	output logic        result_valid
);

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int DATA_W = ADDRESS_BITS + THREAD_COUNT;

	fwt_state_t state_q, state_d;

	logic [OP_W-1:0]          op_q;
	logic [ADDRESS_BITS-1:0]  key_q;
	logic [THREAD_COUNT-1:0]  bit_q;
	logic [CNT_W-1:0]         limit_q;
	logic [IDX_W-1:0]         idx_q, idx_d;
	logic [THREAD_COUNT-1:0]  wmask_q, wmask_d;
	logic [CNT_W-1:0]         woken_q, woken_d;
	logic [TABLE_ENTRIES-1:0] in_use_q, in_use_d;
	fwt_result_t              result_q, result_d;
	logic                     result_valid_q, result_valid_d;

	logic                     accept;
	logic [63:0]              addr_ext;
	logic [ADDRESS_BITS-1:0]  in_key;
	logic [THREAD_COUNT-1:0]  in_bit;
	logic                     in_tvalid;
	logic [CNT_W-1:0]         in_limit;

	logic                     ram_we;
	logic [DATA_W-1:0]        ram_wdata;
	logic [DATA_W-1:0]        ram_rdata;
	logic [ADDRESS_BITS-1:0]  rd_key;
	logic [THREAD_COUNT-1:0]  rd_mask;
	logic [THREAD_COUNT-1:0]  rd_mask_eff;
	logic [THREAD_COUNT-1:0]  unreg_mask;
	logic                     cur_in_use;
	logic                     match;
	logic                     reg_hit;
	logic                     idx_last;
	logic                     wake_empty;
	logic [TNUM_W-1:0]        pick_thread;
	logic [THREAD_COUNT-1:0]  pick_rest;
	logic [CNT_W-1:0]         woken_next;
	logic                     emit_last;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// input decode
	assign addr_ext  = 64'(item.wait_address);
	assign in_key    = addr_ext[ADDRESS_BITS-1:0];
	assign in_tvalid = ({1'b0, item.thread_number} < CNT_W'(THREAD_COUNT));
	assign in_limit  = (item.wake_limit > CNT_W'(THREAD_COUNT)) ?
		CNT_W'(THREAD_COUNT) : item.wake_limit;

	always_comb begin
		for (int i = 0; i < THREAD_COUNT; i++) begin
			in_bit[i] = (item.thread_number == TNUM_W'(i));
		end
	end

	fwt_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	fwt_pick #(
		.THREAD_COUNT(THREAD_COUNT)
	) u_pick (
		.mask  (wmask_q),
		.thread(pick_thread),
		.rest  (pick_rest)
	);

	// entry compare
	assign rd_key      = ram_rdata[DATA_W-1:THREAD_COUNT];
	assign rd_mask     = ram_rdata[THREAD_COUNT-1:0];
	assign cur_in_use  = in_use_q[idx_q];
	assign rd_mask_eff = cur_in_use ? rd_mask : '0;
	assign match       = cur_in_use && (rd_key == key_q);
	assign reg_hit     = match || !cur_in_use;
	assign unreg_mask  = rd_mask & ~bit_q;
	assign idx_last    = (idx_q == IDX_W'(TABLE_ENTRIES - 1));

	// wake emission
	assign wake_empty = (wmask_q == '0) || (limit_q == '0);
	assign woken_next = woken_q + CNT_W'(1);
	assign emit_last  = (pick_rest == '0) || (woken_next == limit_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_tvalid &&
				    (item.operation == OP_REGISTER || item.operation == OP_UNREGISTER)) begin
					state_d = ST_READ;
				end else if (accept && item.operation == OP_WAKE) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (op_q == OP_REGISTER && reg_hit) begin
					state_d = ST_IDLE;
				end else if (idx_last) begin
					state_d = (op_q == OP_WAKE) ? ST_EMIT : ST_IDLE;
				end else begin
					state_d = ST_READ;
				end
			end
			ST_EMIT: begin
				if (wake_empty || emit_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// datapath and outputs
	always_comb begin
		idx_d          = idx_q;
		wmask_d        = wmask_q;
		woken_d        = woken_q;
		in_use_d       = in_use_q;
		ram_we         = 1'b0;
		ram_wdata      = {key_q, rd_mask_eff | bit_q};
		result_d       = '0;
		result_valid_d = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				idx_d   = '0;
				wmask_d = '0;
				woken_d = '0;
				if (accept && !in_tvalid && item.operation == OP_REGISTER) begin
					result_d.reply_kind  = KIND_FULL;
					result_d.last_result = 1'b1;
					result_valid_d       = 1'b1;
				end else if (accept && !in_tvalid && item.operation == OP_UNREGISTER) begin
					result_d.reply_kind  = KIND_UNREGISTERED;
					result_d.last_result = 1'b1;
					result_valid_d       = 1'b1;
				end
			end
			ST_READ: begin
			end
			ST_CHECK: begin
				if (!idx_last) begin
					idx_d = idx_q + IDX_W'(1);
				end
				priority if (op_q == OP_REGISTER) begin
					if (reg_hit) begin
						ram_we               = 1'b1;
						in_use_d[idx_q]      = 1'b1;
						result_d.reply_kind  = KIND_REGISTERED;
						result_d.last_result = 1'b1;
						result_valid_d       = 1'b1;
					end else if (idx_last) begin
						result_d.reply_kind  = KIND_FULL;
						result_d.last_result = 1'b1;
						result_valid_d       = 1'b1;
					end
				end else if (op_q == OP_UNREGISTER) begin
					if (match) begin
						ram_we    = 1'b1;
						ram_wdata = {key_q, unreg_mask};
						if (unreg_mask == '0) begin
							in_use_d[idx_q] = 1'b0;
						end
					end
					if (idx_last) begin
						result_d.reply_kind  = KIND_UNREGISTERED;
						result_d.last_result = 1'b1;
						result_valid_d       = 1'b1;
					end
				end else begin
					if (match) begin
						wmask_d = wmask_q | rd_mask;
					end
				end
			end
			ST_EMIT: begin
				result_d.reply_kind = KIND_WAKE;
				result_valid_d      = 1'b1;
				if (wake_empty) begin
					result_d.last_result = 1'b1;
				end else begin
					result_d.woken_thread = pick_thread;
					result_d.woken_valid  = 1'b1;
					result_d.woken_so_far = woken_next;
					result_d.last_result  = emit_last;
					wmask_d               = pick_rest;
					woken_d               = woken_next;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			in_use_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			in_use_q       <= in_use_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= item.operation;
			key_q   <= in_key;
			bit_q   <= in_bit;
			limit_q <= in_limit;
		end
		idx_q    <= idx_d;
		wmask_q  <= wmask_d;
		woken_q  <= woken_d;
		result_q <= result_d;
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

### rtl/core/fwt_ram.sv
module fwt_ram import fwt_pkg::*; #(
	parameter int WIDTH = ADDRESS_BITS_DEF + THREAD_COUNT_DEF,
	parameter int DEPTH = TABLE_ENTRIES_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/fwt_pick.sv
module fwt_pick import fwt_pkg::*; #(
	parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
	input  logic [THREAD_COUNT-1:0] mask,
	output logic [TNUM_W-1:0]       thread,
	output logic [THREAD_COUNT-1:0] rest
);

	logic [THREAD_COUNT-1:0] lowest;

	// isolate the lowest set bit
	assign lowest = mask & (~mask + THREAD_COUNT'(1));
	assign rest   = mask & ~lowest;

	always_comb begin
		thread = '0;
		for (int i = 0; i < THREAD_COUNT; i++) begin
			if (lowest[i]) begin
				thread = TNUM_W'(i);
			end
		end
	end

endmodule

### verif/futex_reply_check.sv
`timescale 1ns / 100ps

module futex_reply_check import fwt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  fwt_item_t   item,
	input  fwt_result_t result,
	input  logic        result_valid,
	output int          fail_count,
	output int          awaited_count
);

	logic                        slot_used    [TABLE_ENTRIES_DEF];
	logic [ADDR_W-1:0]           slot_address [TABLE_ENTRIES_DEF];
	logic [THREAD_COUNT_DEF-1:0] slot_threads [TABLE_ENTRIES_DEF];
	fwt_result_t                 awaited_replies [$];
	fwt_result_t                 want;

	function automatic fwt_result_t reply(input logic [KIND_W-1:0] kind,
			input logic [TNUM_W-1:0] thread, input logic valid,
			input logic [CNT_W-1:0] count, input logic last);
		fwt_result_t r;
		r.reply_kind   = kind;
		r.woken_thread = thread;
		r.woken_valid  = valid;
		r.woken_so_far = count;
		r.last_result  = last;
		return r;
	endfunction

	// updates the shadow table for one accepted word and queues its replies
	task automatic apply_table_word(input fwt_item_t w);
		logic                        placed;
		logic [THREAD_COUNT_DEF-1:0] parked;
		int                          cap;
		int                          total;
		int                          woken;
		placed = 1'b0;
		parked = '0;
		woken  = 0;
		case (w.operation)
		OP_REGISTER: begin
			// first entry that is free or already holds this address
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				if (!placed && (!slot_used[i] || slot_address[i] == w.wait_address)) begin
					slot_used[i]    = 1'b1;
					slot_address[i] = w.wait_address;
					slot_threads[i][w.thread_number] = 1'b1;
					placed = 1'b1;
				end
			end
			awaited_replies.push_back(reply(placed ? KIND_REGISTERED : KIND_FULL,
				'0, 1'b0, '0, 1'b1));
		end
		OP_UNREGISTER: begin
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				if (slot_used[i] && slot_address[i] == w.wait_address) begin
					slot_threads[i][w.thread_number] = 1'b0;
					if (slot_threads[i] == '0)
						slot_used[i] = 1'b0;
				end
			end
			awaited_replies.push_back(reply(KIND_UNREGISTERED, '0, 1'b0, '0, 1'b1));
		end
		OP_WAKE: begin
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				if (slot_used[i] && slot_address[i] == w.wait_address)
					parked |= slot_threads[i];
			end
			cap = (w.wake_limit > THREAD_COUNT_DEF) ? THREAD_COUNT_DEF : int'(w.wake_limit);
			total = $countones(parked);
			if (total > cap)
				total = cap;
			if (total == 0)
				awaited_replies.push_back(reply(KIND_WAKE, '0, 1'b0, '0, 1'b1));
			for (int t = 0; t < THREAD_COUNT_DEF; t++) begin
				if (parked[t] && woken < total) begin
					woken++;
					awaited_replies.push_back(reply(KIND_WAKE, TNUM_W'(t), 1'b1,
						CNT_W'(woken), woken == total));
				end
			end
		end
		default: ; // reserved code, dropped without a reply
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
				slot_used[i]    = 1'b0;
				slot_address[i] = '0;
				slot_threads[i] = '0;
			end
			awaited_replies.delete();
			fail_count    <= 0;
			awaited_count <= 0;
		end else begin
			// a reply leaving in the same cycle as a new word arrives belongs to older work
			if (result_valid) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t: reply with none awaited, got kind %0d thread %0d valid %b count %0d last %b",
						$time, result.reply_kind, result.woken_thread, result.woken_valid,
						result.woken_so_far, result.last_result);
					fail_count <= fail_count + 1;
				end else begin
					want = awaited_replies.pop_front();
					if (result.reply_kind !== want.reply_kind ||
							result.woken_thread !== want.woken_thread ||
							result.woken_valid !== want.woken_valid ||
							result.woken_so_far !== want.woken_so_far ||
							result.last_result !== want.last_result) begin
						$display("%0t: reply mismatch, expected kind %0d thread %0d valid %b count %0d last %b",
							$time, want.reply_kind, want.woken_thread, want.woken_valid,
							want.woken_so_far, want.last_result);
						$display("%0t:                 actual kind %0d thread %0d valid %b count %0d last %b",
							$time, result.reply_kind, result.woken_thread, result.woken_valid,
							result.woken_so_far, result.last_result);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (start && !busy)
				apply_table_word(item);
			awaited_count <= awaited_replies.size();
		end
	end

endmodule

### verif/futex_waiter_table_tb.sv
`timescale 1ns / 100ps

module futex_waiter_table_tb;
	import fwt_pkg::*;

	localparam logic [OP_W-1:0] OP_RESERVED  = 2'd3;
	localparam int              RANDOM_WORDS = 260;
	localparam int              POOL_SIZE    = 20;
	localparam int unsigned     CYCLE_LIMIT  = 200000;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              start  = 1'b0;
	fwt_item_t         item   = '0;
	logic              busy;
	fwt_result_t       result;
	logic              result_valid;
	int                fail_count;
	int                awaited_count;
	int unsigned       cycle_count;
	logic              no_gaps = 1'b0;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	always #5 clk = ~clk;

	futex_waiter_table DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result       (result),
		.result_valid (result_valid)
	);

	futex_reply_check reply_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.result        (result),
		.result_valid  (result_valid),
		.fail_count    (fail_count),
		.awaited_count (awaited_count)
	);

	// returns at the rising edge where the word was taken
	task automatic send_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [TNUM_W-1:0] thread, input logic [CNT_W-1:0] limit);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= {op, addr, thread, limit};
		// busy only moves on rising edges, so the falling edge gives a settled look
		do @(negedge clk); while (busy);
		@(posedge clk);
	endtask

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int                pick;
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [TNUM_W-1:0] thread;
		logic [CNT_W-1:0]  limit;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		addr_pool[2] = 48'h5555_5555_5555;
		addr_pool[3] = 48'hAAAA_AAAA_AAAA;
		for (int i = 4; i < POOL_SIZE; i++)
			addr_pool[i] = ADDR_W'({$urandom, $urandom});
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, address zero, top thread, saturating and zero limits
		send_word(OP_WAKE, addr_pool[0], 5'd0, 6'd5);
		send_word(OP_REGISTER, addr_pool[0], 5'd0, 6'd0);
		send_word(OP_REGISTER, addr_pool[1], 5'd31, 6'd63);
		send_word(OP_REGISTER, addr_pool[0], 5'd31, 6'd0);
		send_word(OP_WAKE, addr_pool[0], 5'd0, 6'd63);
		send_word(OP_WAKE, addr_pool[0], 5'd31, 6'd0);
		send_word(OP_RESERVED, addr_pool[0], 5'd0, 6'd1);
		send_word(OP_UNREGISTER, addr_pool[0], 5'd0, 6'd0);
		send_word(OP_UNREGISTER, addr_pool[0], 5'd31, 6'd0);
		// fill every entry, then a new address finds the table full
		for (int i = 2; i <= 16; i++)
			send_word(OP_REGISTER, addr_pool[i], TNUM_W'(i), 6'd0);
		send_word(OP_REGISTER, addr_pool[17], 5'd3, 6'd0);
		send_word(OP_REGISTER, addr_pool[1], 5'd7, 6'd0);
		send_word(OP_WAKE, addr_pool[1], 5'd0, 6'd32);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			no_gaps = (n % 50) < 12;
			pick = $urandom_range(0, 99);
			op = (pick < 45) ? OP_REGISTER :
				(pick < 70) ? OP_UNREGISTER :
				(pick < 97) ? OP_WAKE : OP_RESERVED;
			if ($urandom_range(0, 99) < 88)
				addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				addr = ADDR_W'({$urandom, $urandom});
			// a few threads per address keep entries getting freed again
			if ($urandom_range(0, 99) < 70)
				thread = TNUM_W'($urandom_range(0, 7));
			else
				thread = TNUM_W'($urandom_range(0, 31));
			case ($urandom_range(0, 3))
			0: limit = CNT_W'($urandom_range(0, 63));
			1: limit = CNT_W'($urandom_range(1, 4));
			2: limit = CNT_W'(THREAD_COUNT_DEF);
			default: limit = CNT_W'($urandom_range(0, 32));
			endcase
			send_word(op, addr, thread, limit);
		end
		start <= 1'b0;

		do @(negedge clk); while (awaited_count != 0 || busy);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
